### design/srcv_pkg.sv
// ----------------------------------------------------------------------------
// srcv_pkg - shared types and helpers for the state record CRC verifier
// Status codes, header layout constants and the bytewise CRC-32 update.
// ----------------------------------------------------------------------------
package srcv_pkg;

  localparam int unsigned CntWidth = 17;
  localparam int unsigned LenWidth = 16;

  localparam logic [CntWidth-1:0] HdrBytes    = 17'd16;
  localparam logic [CntWidth-1:0] HdrCrcBytes = 17'd12;
  localparam logic [CntWidth-1:0] CntMax      = 17'h1FFFF;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_HDR_CRC   = 3'd2,
    ST_MAGIC     = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_DATA_CRC  = 3'd5
  } status_t;

  // Header field selected by byte position bits [3:2]
  typedef enum logic [1:0] {
    FLD_MAGIC    = 2'd0,
    FLD_LENGTH   = 2'd1,
    FLD_DATA_CRC = 2'd2,
    FLD_HDR_CRC  = 2'd3
  } hdr_field_t;

  // Reflected CRC-32, one byte per call
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/state_record_crc_verifier.sv
// ----------------------------------------------------------------------------
// state_record_crc_verifier - streaming check of a CRC-framed stored record
// Parses the 16-byte header, runs CRC-32 over header and data, reports status.
// ----------------------------------------------------------------------------
// Usage:
//   Record bytes enter on data_byte/last_byte with data_valid/data_stall, one
//   item per cycle unless stalled. The item carrying last_byte = 1 produces
//   one result item (status, used_length) on result_valid/result_stall;
//   other items produce none. used_length is zero unless status is ok.
//   The result is registered and shows in the cycle after the final byte is
//   accepted. Throughput: one byte per cycle while data_stall is low, set by
//   the single bytewise CRC update plus the final compares between the record
//   state registers and the result register.
//   Stall: a waiting result holds its value. Non-final bytes keep flowing
//   while the result waits; a final byte is held off (data_stall high) only
//   while the result register is full and stalled.
//   magic_wr_en/magic_wr_data write the expected magic (zero skips the magic
//   check); write it only while no record is in flight.
//   Reset: synchronous rst clears the record state, the result valid flag
//   and the expected magic. After each final byte the record state clears so
//   the next record can start in the following cycle.
// ----------------------------------------------------------------------------
module state_record_crc_verifier
  import srcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        magic_wr_en,
  input  logic [31:0] magic_wr_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [16:0] used_length
);

  logic [31:0]         expected_magic;
  logic [CntWidth-1:0] byte_counter, byte_counter_next;
  logic [31:0]         magic_word, magic_word_next;
  logic [LenWidth-1:0] length_word, length_word_next;
  logic [31:0]         stored_data_crc, stored_data_crc_next;
  logic [31:0]         stored_header_crc, stored_header_crc_next;
  logic [31:0]         computed_header_crc, computed_header_crc_next;
  logic [31:0]         running_crc, running_crc_next;

  logic                accept;
  logic [31:0]         crc_upd;
  logic [CntWidth-1:0] data_end;
  logic [31:0]         lane_val;
  status_t             status_next;
  logic [16:0]         used_next;

  assign data_stall = result_valid & result_stall & last_byte;
  assign accept     = data_valid & ~data_stall;

  assign crc_upd  = crc_byte(running_crc, data_byte);
  assign data_end = HdrBytes + {1'b0, length_word};
  assign lane_val = {24'd0, data_byte} << {byte_counter[1:0], 3'b000};

  always_comb begin
    magic_word_next          = magic_word;
    length_word_next         = length_word;
    stored_data_crc_next     = stored_data_crc;
    stored_header_crc_next   = stored_header_crc;
    computed_header_crc_next = computed_header_crc;
    running_crc_next         = running_crc;

    // header field capture, little-endian
    if (byte_counter < HdrBytes) begin
      case (hdr_field_t'(byte_counter[3:2]))
        FLD_MAGIC:    magic_word_next = magic_word | lane_val;
        FLD_LENGTH: begin
          // bytes 4..5 are reserved
          if (byte_counter[1]) begin
            length_word_next = length_word |
                               (LenWidth'({8'd0, data_byte}) << {byte_counter[0], 3'b000});
          end
        end
        FLD_DATA_CRC: stored_data_crc_next = stored_data_crc | lane_val;
        FLD_HDR_CRC:  stored_header_crc_next = stored_header_crc | lane_val;
        default: ;
      endcase
    end

    if (byte_counter < HdrCrcBytes) begin
      if (byte_counter == HdrCrcBytes - 17'd1) begin
        computed_header_crc_next = ~crc_upd;
        running_crc_next         = CrcInit;
      end else begin
        running_crc_next = crc_upd;
      end
    end else if (byte_counter >= HdrBytes && byte_counter < data_end) begin
      running_crc_next = crc_upd;
    end

    byte_counter_next = (byte_counter == CntMax) ? byte_counter
                                                 : byte_counter + 17'd1;
  end

  // checks in status code order, on the state including the final byte
  always_comb begin
    used_next = 17'd0;
    if (byte_counter_next < HdrBytes) begin
      status_next = ST_SHORT;
    end else if (computed_header_crc_next != stored_header_crc_next) begin
      status_next = ST_HDR_CRC;
    end else if (expected_magic != 32'd0 && expected_magic != magic_word_next) begin
      status_next = ST_MAGIC;
    end else if ((HdrBytes + {1'b0, length_word_next}) > byte_counter_next) begin
      status_next = ST_LENGTH;
    end else if (~running_crc_next != stored_data_crc_next) begin
      status_next = ST_DATA_CRC;
    end else begin
      status_next = ST_OK;
      used_next   = HdrBytes + {1'b0, length_word_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= 32'd0;
    end else if (magic_wr_en) begin
      expected_magic <= magic_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_counter        <= '0;
      magic_word          <= 32'd0;
      length_word         <= '0;
      stored_data_crc     <= 32'd0;
      stored_header_crc   <= 32'd0;
      computed_header_crc <= 32'd0;
      running_crc         <= CrcInit;
    end else if (accept) begin
      byte_counter        <= byte_counter_next;
      magic_word          <= magic_word_next;
      length_word         <= length_word_next;
      stored_data_crc     <= stored_data_crc_next;
      stored_header_crc   <= stored_header_crc_next;
      computed_header_crc <= computed_header_crc_next;
      running_crc         <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      status      <= status_next;
      used_length <= used_next;
    end
  end

endmodule

### design/srcv_checker.sv
// ----------------------------------------------------------------------------
// srcv_checker - port-level checks for the state record CRC verifier
// Watches result and byte ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module srcv_checker
  import srcv_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        data_valid,
  input logic        data_stall,
  input logic        last_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic [16:0] used_length
);

  // a stalled result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) &&
                                     $stable(used_length))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= ST_DATA_CRC)
    else $error("status code out of range");

  a_used_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> used_length == 17'd0)
    else $error("used length nonzero on failed record");

  a_used_min: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_OK |-> used_length >= HdrBytes)
    else $error("used length shorter than header");

  // a result only follows an accepted final byte or a held result
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && result_valid |->
      $past(data_valid && !data_stall && last_byte) ||
      $past(result_valid && result_stall))
    else $error("result without a final byte");

endmodule

bind state_record_crc_verifier srcv_checker u_srcv_checker (
  .clk          (clk),
  .rst          (rst),
  .data_valid   (data_valid),
  .data_stall   (data_stall),
  .last_byte    (last_byte),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .used_length  (used_length)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for state_record_crc_verifier
// Streams framed records (valid, corrupted, truncated, noise) into the block
// and checks each status/used_length against a cycle-free CRC-32 predictor,
// with random gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
  import srcv_pkg::*;

  localparam int unsigned HDR_LEN    = 16;
  localparam int unsigned COUNT_CEIL = 17'h1FFFF;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;

  typedef enum {
    FLT_NONE,
    FLT_SHORT,
    FLT_HDR_CRC,
    FLT_MAGIC,
    FLT_LENGTH,
    FLT_DATA_CRC
  } fault_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } rec_byte_t;

  typedef struct packed {
    status_t     st;
    logic [16:0] used;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        magic_wr_en = 1'b0;
  logic [31:0] magic_wr_data = '0;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  status;
  logic [16:0] used_length;

  state_record_crc_verifier uut (
    .clk          (clk),
    .rst          (rst),
    .magic_wr_en  (magic_wr_en),
    .magic_wr_data(magic_wr_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .used_length  (used_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  rec_byte_t   pending_bytes[$];
  verdict_t    verdicts_due[$];
  logic [7:0]  scratch[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          errors = 0;
  logic        byte_taken = 1'b0;
  rec_byte_t   next_out;
  verdict_t    got_due;

  // Idling control
  int max_gap = 40;
  int send_gap = 0;
  int send_quiet = 0;
  int stall_left = 0;
  int stall_quiet = 0;

  // Predicted block state
  logic [31:0] magic_setting = '0;
  logic [16:0] rec_pos;
  logic [31:0] rec_magic;
  logic [15:0] rec_len;
  logic [31:0] rec_dcrc;
  logic [31:0] rec_hcrc;
  logic [31:0] rec_hcrc_calc;
  logic [31:0] rec_crc;

  function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[31:1]} ^ (fb ? CRC32_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic int pick_gap(input int ceiling);
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92 || ceiling <= 3) return $urandom_range(1, (ceiling < 3) ? ceiling : 3);
    return $urandom_range(4, ceiling);
  endfunction

  task automatic clear_record();
    rec_pos = '0;
    rec_magic = '0;
    rec_len = '0;
    rec_dcrc = '0;
    rec_hcrc = '0;
    rec_hcrc_calc = '0;
    rec_crc = '1;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    int unsigned span;
    int unsigned total;
    verdict_t    v;
    pos = 32'(rec_pos);
    if (pos < 4) rec_magic[8*pos +: 8] = b;
    else if (pos == 6 || pos == 7) rec_len[8*(pos-6) +: 8] = b;
    else if (pos >= 8 && pos < 12) rec_dcrc[8*(pos-8) +: 8] = b;
    else if (pos >= 12 && pos < 16) rec_hcrc[8*(pos-12) +: 8] = b;

    span = HDR_LEN + rec_len;
    if (pos < 12) begin
      rec_crc = crc32_byte(rec_crc, b);
      if (pos == 11) begin
        rec_hcrc_calc = ~rec_crc;
        rec_crc = '1;
      end
    end else if (pos >= HDR_LEN && pos < span) begin
      rec_crc = crc32_byte(rec_crc, b);
    end

    if (rec_pos != COUNT_CEIL) rec_pos = rec_pos + 1'b1;

    if (last) begin
      total = 32'(rec_pos);
      v.used = '0;
      if (total < HDR_LEN) v.st = ST_SHORT;
      else if (rec_hcrc_calc != rec_hcrc) v.st = ST_HDR_CRC;
      else if (magic_setting != 0 && magic_setting != rec_magic) v.st = ST_MAGIC;
      else if (span > total) v.st = ST_LENGTH;
      else if (~rec_crc != rec_dcrc) v.st = ST_DATA_CRC;
      else begin
        v.st = ST_OK;
        v.used = 17'(span);
      end
      verdicts_due.push_back(v);
      clear_record();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    rec_byte_t e;
    e.value = b;
    e.last = last;
    pending_bytes.push_back(e);
    bytes_queued++;
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), i == n - 1);
  endtask

  // Builds one framed record; cut > 0 forces the buffer length.
  task automatic queue_record(input int body_len, input fault_t fault, input int slack,
                              input int fill, input int cut);
    logic [7:0]  hdr[16];
    logic [7:0]  b;
    logic [31:0] magic;
    logic [31:0] dcrc;
    logic [31:0] hcrc;
    int          total;
    int          spot;
    scratch.delete();
    dcrc = '1;
    for (int i = 0; i < body_len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      scratch.push_back(b);
      dcrc = crc32_byte(dcrc, b);
    end
    dcrc = ~dcrc;
    if (fault == FLT_DATA_CRC) begin
      if (body_len > 0 && $urandom_range(1) == 1) begin
        spot = $urandom_range(body_len - 1);
        scratch[spot] = scratch[spot] ^ (8'd1 << $urandom_range(7));
      end else begin
        dcrc = dcrc ^ (32'd1 << $urandom_range(31));
      end
    end

    // other faults sometimes carry a wrong magic too, to exercise check order
    if (fault == FLT_MAGIC) magic = magic_setting ^ ((32'd1 << $urandom_range(31)) | $urandom);
    else if (magic_setting != 0 && (fault == FLT_NONE || $urandom_range(3) != 0))
      magic = magic_setting;
    else magic = $urandom;

    for (int i = 0; i < 4; i++) begin
      hdr[i] = magic[8*i +: 8];
      hdr[8+i] = dcrc[8*i +: 8];
    end
    hdr[4] = 8'($urandom_range(255));
    hdr[5] = 8'($urandom_range(255));
    hdr[6] = body_len[7:0];
    hdr[7] = body_len[15:8];
    hcrc = '1;
    for (int i = 0; i < 12; i++) hcrc = crc32_byte(hcrc, hdr[i]);
    hcrc = ~hcrc;
    if (fault == FLT_HDR_CRC) begin
      if ($urandom_range(1) == 1) begin
        hcrc = hcrc ^ (32'd1 << $urandom_range(31));
      end else begin
        spot = $urandom_range(11);
        hdr[spot] = hdr[spot] ^ (8'd1 << $urandom_range(7));
      end
    end
    for (int i = 0; i < 4; i++) hdr[12+i] = hcrc[8*i +: 8];

    for (int i = 0; i < slack; i++) scratch.push_back(8'($urandom_range(255)));
    total = HDR_LEN + scratch.size();
    if (cut > 0) total = cut;
    else if (fault == FLT_SHORT) total = $urandom_range(1, 15);
    else if (fault == FLT_LENGTH) total = HDR_LEN + $urandom_range(body_len - 1);
    for (int i = 0; i < total; i++)
      queue_byte((i < HDR_LEN) ? hdr[i] : scratch[i - HDR_LEN], i == total - 1);
  endtask

  task automatic random_records(input int budget);
    int     start;
    int     r;
    int     len;
    int     slack;
    fault_t f;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(99);
      if (r < 80) len = $urandom_range(12);
      else if (r < 97) len = $urandom_range(13, 64);
      else len = $urandom_range(65, 300);
      slack = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 6);
      r = $urandom_range(99);
      if (r < 55) f = FLT_NONE;
      else if (r < 62) f = FLT_SHORT;
      else if (r < 70) f = FLT_HDR_CRC;
      else if (r < 78) f = FLT_MAGIC;
      else if (r < 86) f = FLT_LENGTH;
      else f = FLT_DATA_CRC;
      if (r >= 94) begin
        queue_noise(($urandom_range(1) == 1) ? $urandom_range(1, 3) : $urandom_range(4, 40));
      end else begin
        if (f == FLT_LENGTH && len == 0) len = 1;
        queue_record(len, f, slack, -1, 0);
      end
    end
  endtask

  // Waits until every byte is in and every result is out, then lets the
  // registered result path settle.
  task automatic drain();
    while (bytes_taken != bytes_queued || verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_magic(input logic [31:0] value);
    @(negedge clk);
    magic_wr_en <= 1'b1;
    magic_wr_data <= value;
    magic_setting = value;
    @(negedge clk);
    magic_wr_en <= 1'b0;
  endtask

  // Byte acceptance and prediction
  always @(posedge clk) begin
    byte_taken = !rst && data_valid && !data_stall;
    if (byte_taken) begin
      absorb_byte(data_byte, last_byte);
      bytes_taken++;
    end
  end

  // Byte driver
  always @(negedge clk) begin
    if (!rst && (!data_valid || byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        data_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        next_out = pending_bytes.pop_front();
        data_byte <= next_out.value;
        last_byte <= next_out.last;
        data_valid <= 1'b1;
        if (send_quiet > 0) begin
          send_quiet--;
          send_gap = 0;
        end else begin
          if ($urandom_range(40) == 0) send_quiet = $urandom_range(20, 120);
          send_gap = pick_gap(max_gap);
        end
      end else begin
        data_valid <= 1'b0;
      end
    end
  end

  // Result stall driver
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      if (stall_quiet > 0) stall_quiet--;
      else if ($urandom_range(99) < 8) stall_quiet = $urandom_range(30, 150);
      else if ($urandom_range(3) == 0) stall_left = pick_gap(40);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result with nothing expected: status %0d used_length %0d",
               status, used_length);
        errors++;
      end else begin
        got_due = verdicts_due.pop_front();
        if (status !== got_due.st) begin
          $error("status: expected %0d, got %0d", got_due.st, status);
          errors++;
        end
        if (used_length !== got_due.used) begin
          $error("used_length: expected %0d, got %0d", got_due.used, used_length);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_record();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // magic check off after reset
    queue_record(0, FLT_SHORT, 0, -1, 1);
    queue_record(0, FLT_SHORT, 0, -1, 15);
    queue_record(0, FLT_NONE, 0, -1, 0);
    queue_record(4, FLT_NONE, 0, 8'h00, 0);
    queue_record(4, FLT_NONE, 3, 8'hFF, 0);
    queue_record(5, FLT_HDR_CRC, 0, -1, 0);
    queue_record(5, FLT_LENGTH, 0, -1, 20);
    queue_record(5, FLT_LENGTH, 0, -1, 16);
    queue_record(65535, FLT_LENGTH, 0, -1, 40);
    queue_record(6, FLT_DATA_CRC, 0, -1, 0);
    queue_record(0, FLT_DATA_CRC, 2, -1, 0);
    queue_noise(1);
    queue_noise(1);
    drain();

    set_magic(32'hFFFF_FFFF);
    queue_record(3, FLT_NONE, 0, -1, 0);
    queue_record(3, FLT_MAGIC, 0, -1, 0);
    queue_record(0, FLT_MAGIC, 1, -1, 0);
    random_records(340);
    drain();

    set_magic($urandom);
    random_records(340);
    drain();

    set_magic(32'h0000_0001);
    random_records(340);
    drain();

    set_magic(32'h0000_0000);
    random_records(340);
    drain();

    set_magic(32'h8000_0000);
    random_records(340);
    drain();

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
